[sv/srt_pkg.sv]
package srt_pkg;

  // Candidate width; candidates are taken modulo 2^VALUE_WIDTH
  localparam int unsigned VALUE_WIDTH = 16;
  // Bit counter width for the one-bit-per-cycle divider
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH);
  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Smallest semiprime
  localparam int unsigned MIN_SEMIPRIME = 4;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Input transfer payload
  typedef struct packed {
    value_t candidate;
    logic   range_end;
  } srt_in_t;

  // Result transfer payload
  typedef struct packed {
    value_t tested_value;
    logic   semiprime_flag;
    logic   any_found;
    logic   range_done;
  } srt_out_t;

  // Queue entry handed from front to back
  typedef struct packed {
    value_t value;
    logic   last;
    logic   trivial;  // below the smallest semiprime, no division needed
  } srt_item_t;

endpackage

[sv/srt_front.sv]
module srt_front
  import srt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  srt_in_t   in_data_i,
  output logic      item_valid_o,
  input  logic      item_pop_i,
  output srt_item_t item_o
);

  srt_item_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   cnt_q, cnt_d;
  logic                     wr_en, rd_en;
  srt_item_t                new_item;

  // Classify: tiny values skip the divider
  always_comb begin
    new_item.value   = in_data_i.candidate;
    new_item.last    = in_data_i.range_end;
    new_item.trivial = (in_data_i.candidate < value_t'(MIN_SEMIPRIME));
  end

  assign full         = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_pop_i && item_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[sv/srt_back.sv]
module srt_back
  import srt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_pop_o,
  input  srt_item_t item_i,
  output logic      empty,
  input  logic      pop,
  output srt_out_t  out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  value_t                   m_q, m_d;        // remaining cofactor
  value_t                   d_q, d_d;        // trial divisor
  logic [2*VALUE_WIDTH-1:0] dsq_q, dsq_d;    // d squared
  logic [1:0]               cnt_q, cnt_d;    // prime factors found
  value_t                   rem_q, rem_d;
  value_t                   quo_q, quo_d;
  logic [BIT_CNT_W-1:0]     bit_q, bit_d;
  value_t                   val_q, val_d;
  logic                     last_q, last_d;
  logic                     semi_q, semi_d;
  logic                     seen_q, seen_d;
  logic                     out_valid_q, out_valid_d;
  srt_out_t                 out_q, out_d;

  logic [VALUE_WIDTH:0]     rem_sh, rem_sub;
  logic                     ge;
  logic                     any;

  // One restoring division step
  assign rem_sh  = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge      = (rem_sh >= {1'b0, d_q});
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign any     = seen_q || semi_q;

  // Trial division sequencer
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    d_d         = d_q;
    dsq_d       = dsq_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    val_d       = val_q;
    last_d      = last_q;
    semi_d      = semi_q;
    seen_d      = seen_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    item_pop_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          val_d      = item_i.value;
          last_d     = item_i.last;
          m_d        = item_i.value;
          d_d        = value_t'(2);
          dsq_d      = (2*VALUE_WIDTH)'(4);
          cnt_d      = '0;
          semi_d     = 1'b0;
          state_d    = item_i.trivial ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (dsq_q > {{VALUE_WIDTH{1'b0}}, m_q}) begin
          // leftover cofactor above one is a last prime factor
          semi_d  = ((cnt_q + {1'b0, (m_q > value_t'(1))}) == 2'd2);
          state_d = S_DONE;
        end else begin
          rem_d   = '0;
          quo_d   = m_q;
          bit_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rem_q == '0) begin
          if (cnt_q == 2'd2) begin
            // third factor: not a semiprime
            semi_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            m_d     = quo_q;
            cnt_d   = cnt_q + 1'b1;
            state_d = S_CHECK;
          end
        end else begin
          d_d     = d_q + 1'b1;
          dsq_d   = dsq_q + {{(VALUE_WIDTH-1){1'b0}}, d_q, 1'b1};
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || pop) begin
          out_d.tested_value   = val_q;
          out_d.semiprime_flag = semi_q;
          out_d.any_found      = last_q && any;
          out_d.range_done     = last_q;
          out_valid_d          = 1'b1;
          seen_d               = last_q ? 1'b0 : any;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    d_q    <= d_d;
    dsq_q  <= dsq_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    val_q  <= val_d;
    last_q <= last_d;
    semi_q <= semi_d;
    out_q  <= out_d;
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  // Factor count never passes two
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("factor count overflow");

  // A new result only appears when leaving the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without done");

  // Divider bit count stays at zero outside division
  a_bit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> (bit_q == '0)) else $error("bit count");

  // Queue entry is only taken when the engine is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (state_q == S_IDLE && item_valid_i)) else $error("bad queue pop");
`endif

endmodule

[sv/semiprime_range_tester_core.sv]
// Semiprime range tester. Push candidates of a range one per transfer, with
// range_end set on the last one; each transfer yields one result in order
// with the candidate, its semiprime flag (product of exactly two primes,
// squares included), and on the last item any_found, which tells whether the
// range held a semiprime; the sticky flag then clears. Items are tested one
// at a time by trial division with a one-bit-per-cycle divider: each trial
// divisor goes through a bound check, VALUE_WIDTH divide steps and a
// remainder check. In the back end an item below 4 is taken from the queue
// and its result written with no division; a larger one is divided by each
// trial divisor up to the square root. An item waits in the done state
// while the result register still holds an unpopped result. A two-entry
// queue takes new candidates while the divider works, and a result register
// holds the finished result until popped.
module semiprime_range_tester_core
  import srt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  srt_in_t  in_data_i,
  output logic     empty,
  input  logic     pop,
  output srt_out_t out_data_o
);

  logic      item_valid;
  logic      item_pop;
  srt_item_t item;

  srt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  srt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .empty        (empty),
    .pop          (pop),
    .out_data_o   (out_data_o)
  );

endmodule

[verif/tb.sv]
module tb
  import srt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT   = 50000;  // cycles without any transfer
  localparam int unsigned TAIL_CYCLES  = 5000;   // more than one full trial division
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  srt_in_t  in_data_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  srt_out_t out_data_o;

  // Predictor state and expected verdicts in arrival order
  logic         range_has_semi = 1'b0;
  srt_out_t     pending_verdicts[$];

  int unsigned  send_idle_pct = 0;
  int unsigned  pop_stall_pct = 0;
  int unsigned  hold_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  verdicts_checked = 0;
  int unsigned  ranges_closed = 0;
  int unsigned  semis_seen = 0;
  int unsigned  full_stalls = 0;

  semiprime_range_tester_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Count prime factors with multiplicity; two means semiprime
  function automatic logic is_two_prime_product(value_t v);
    int unsigned m;
    int unsigned d;
    int unsigned nf;
    m = 32'(v);
    nf = 0;
    if (m < 4) return 1'b0;
    for (d = 2; d * d <= m; d++) begin
      while (m % d == 0) begin
        m = m / d;
        nf++;
      end
    end
    if (m > 1) nf++;
    return nf == 2;
  endfunction

  // Expected verdict for an accepted candidate, sticky flag updated
  function automatic void predict_verdict(srt_in_t item);
    srt_out_t v;
    logic     semi;
    semi = is_two_prime_product(item.candidate);
    range_has_semi = range_has_semi | semi;
    v.tested_value   = item.candidate;
    v.semiprime_flag = semi;
    v.any_found      = item.range_end & range_has_semi;
    v.range_done     = item.range_end;
    if (item.range_end) begin
      range_has_semi = 1'b0;
      ranges_closed++;
    end
    if (semi) semis_seen++;
    pending_verdicts.push_back(v);
  endfunction

  // One candidate transfer; push stays high so back-to-back items need no gap
  task automatic send_item(input value_t cand, input logic last);
    srt_in_t item;
    item.candidate = cand;
    item.range_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (full);
    predict_verdict(item);
    items_sent++;
  endtask

  // Result side: check each transfer, then decide the next pop
  initial begin
    srt_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        verdicts_checked++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: unexpected result value=%0d flag=%0b any=%0b done=%0b",
                     out_data_o.tested_value, out_data_o.semiprime_flag,
                     out_data_o.any_found, out_data_o.range_done);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data_o.tested_value !== want.tested_value ||
              out_data_o.semiprime_flag !== want.semiprime_flag ||
              out_data_o.any_found !== want.any_found ||
              out_data_o.range_done !== want.range_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"ERROR: exp value=%0d flag=%0b any=%0b done=%0b,",
                        " got value=%0d flag=%0b any=%0b done=%0b"},
                       want.tested_value, want.semiprime_flag, want.any_found,
                       want.range_done, out_data_o.tested_value,
                       out_data_o.semiprime_flag, out_data_o.any_found,
                       out_data_o.range_done);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer; also counts input stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) full_stalls++;
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Zero through nine, one range; covers zero, one, primes, squares, cubes
  task automatic test_small_values();
    int unsigned k;
    for (k = 0; k < 10; k++) send_item(value_t'(k), k == 9);
  endtask

  // Ranges of a single number, with and without a semiprime
  task automatic test_single_item_ranges();
    send_item(16'd4, 1'b1);
    send_item(16'd7, 1'b1);
  endtask

  // Range with no semiprime at all: any_found must stay low
  task automatic test_empty_range();
    send_item(16'd11, 1'b0);
    send_item(16'd8, 1'b1);
  endtask

  // Numbers out of order are still tested one by one
  task automatic test_unordered_range();
    send_item(16'd15, 1'b0);
    send_item(16'd49, 1'b0);
    send_item(16'd12, 1'b1);
  endtask

  // Top of the value range: largest prime, all ones, top bit alone, big semiprime
  task automatic test_wide_values();
    send_item(16'd65521, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'd64507, 1'b1);
  endtask

  // Receiver holds off while the sender keeps pushing until the block is full
  task automatic test_backpressure();
    int unsigned k;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_cnt = HOLD_CYCLES;
    for (k = 0; k < 8; k++) send_item(value_t'(20 + k), k == 7);
  endtask

  // Random ranges, mostly short consecutive runs of small numbers
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned base;
    int unsigned k;
    value_t      cand;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      if (len > n_items - sent) len = n_items - sent;
      if ($urandom_range(99) < 80) base = $urandom_range(0, 1000);
      else base = $urandom_range(0, 65535 - 8);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 10) cand = value_t'($urandom_range(0, 65535));
        else cand = value_t'(base + k);
        send_item(cand, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_values();
    test_single_item_ranges();
    test_empty_range();
    test_unordered_range();
    test_wide_values();
    test_backpressure();

    // Idle phases: none, sender idle, receiver stalling, both light
    send_idle_pct = 0;  pop_stall_pct = 0;  test_random_traffic(28);
    send_idle_pct = 87; pop_stall_pct = 0;  test_random_traffic(28);
    send_idle_pct = 0;  pop_stall_pct = 87; test_random_traffic(28);
    send_idle_pct = 13; pop_stall_pct = 13; test_random_traffic(28);

    // Drain, then watch for stray results
    push <= 1'b0;
    pop_stall_pct = 0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_verdicts.size() != 0) mismatches++;

    $display("Checked %0d results for %0d candidates over %0d ranges (%0d semiprimes).",
             verdicts_checked, items_sent, ranges_closed, semis_seen);
    $display("Input held off by a full block in %0d cycles; %0d mismatches.",
             full_stalls, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
